// ===== rtl/ckr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ckr_pkg
// Shared types, constants and the keyword table for the C keyword recogniser.
// ---------------------------------------------------------------------------
package ckr_pkg;

    localparam int KW_TABLE_SIZE       = 44;
    localparam int KW_SLOT             = 16;
    localparam int DEF_KEYWORD_COUNT   = 44;
    localparam int DEF_MAX_WORD_LENGTH = 14;
    localparam int CHAR_W              = 21;
    localparam int INDEX_W             = 6;
    localparam int POS_W               = 4;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    // Keyword text, right-aligned: the last character sits in the low byte.
    localparam logic [KW_SLOT*8-1:0] KW_TEXT [KW_TABLE_SIZE] = '{
        "auto", "break", "case", "char", "const", "continue", "default", "do",
        "double", "else", "enum", "extern", "float", "for", "goto", "if",
        "inline", "int", "long", "register", "restrict", "return", "short",
        "signed", "sizeof", "static", "struct", "switch", "typedef", "union",
        "unsigned", "void", "volatile", "while", "_Alignas", "_Alignof",
        "_Atomic", "_Bool", "_Complex", "_Generic", "_Imaginary", "_Noreturn",
        {"_Static", "_assert"}, {"_Thread", "_local"}
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_TABLE_SIZE] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8, 4'd7, 4'd2,
        4'd6, 4'd4, 4'd4, 4'd6, 4'd5, 4'd3, 4'd4, 4'd2,
        4'd6, 4'd3, 4'd4, 4'd8, 4'd8, 4'd6, 4'd5,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd5,
        4'd8, 4'd4, 4'd8, 4'd5, 4'd8, 4'd8,
        4'd7, 4'd5, 4'd8, 4'd8, 4'd10, 4'd9,
        4'd14, 4'd13
    };

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] keyword_index;
    } t_result;

    // Character of keyword k at position p; zero past the end of the keyword.
    function automatic logic [7:0] kw_char(input int k, input logic [POS_W-1:0] p);
        logic [KW_SLOT*8-1:0] text;
        logic [POS_W-1:0]     len;
        logic [POS_W-1:0]     byte_sel;
        text     = KW_TEXT[k];
        len      = KW_LEN[k];
        byte_sel = len - p - 4'd1;
        if (p >= len) begin
            return 8'h00;
        end
        return text[byte_sel*8 +: 8];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/c_keyword_recognizer.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// c_keyword_recognizer
// Recognises the C11 keywords from a character stream, one character an item.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_stall): one item per character, i_is_end = 0
//    with i_char_code holding the code point, or i_is_end = 1 to close a word.
//  - Output channel (o_valid / i_stall): one item per end marker, o_found
//    and o_keyword_index (table order, 0 when not found). Characters give
//    no output item.
//  - Throughput: one item a cycle while neither channel stalls; every keyword
//    is compared in parallel against the character at the current position.
//  - Path: an accepted end marker passes the input register, then the
//    result register, which raises o_valid.
//  - Stall: while i_stall holds a pending result, the input register waits
//    and o_stall rises once it is occupied; the result payload holds.
//  - Reset: synchronous, active low; empty pipeline, all keywords alive,
//    position zero. After each end marker the same state is restored.
//  - Overlong words, non-ASCII characters and the empty word never match.
// ---------------------------------------------------------------------------
module c_keyword_recognizer
    import ckr_pkg::*;
#(
    parameter int KEYWORD_COUNT   = DEF_KEYWORD_COUNT,
    parameter int MAX_WORD_LENGTH = DEF_MAX_WORD_LENGTH
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [CHAR_W-1:0]  i_char_code,
    input  wire logic               i_is_end,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic                    o_found,
    output logic [INDEX_W-1:0]      o_keyword_index
);

    localparam int ACTIVE_COUNT = (KEYWORD_COUNT < KW_TABLE_SIZE) ? KEYWORD_COUNT
                                                                  : KW_TABLE_SIZE;

    // input register
    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_code;
    logic              r_in_end;

    // per-word state
    logic [ACTIVE_COUNT-1:0] r_mask;
    logic [POS_W-1:0]        r_pos;

    // result register
    logic    r_out_valid;
    t_result r_result;

    logic [ACTIVE_COUNT-1:0] n_mask;
    logic [POS_W-1:0]        n_pos;
    t_result                 n_result;
    logic                    advance;
    logic                    accept;

    ckr_match #(
        .ACTIVE_COUNT    (ACTIVE_COUNT),
        .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
    ) u_match (
        .i_char_code (r_in_code),
        .i_mask      (r_mask),
        .i_pos       (r_pos),
        .o_mask_next (n_mask),
        .o_pos_next  (n_pos),
        .o_result    (n_result)
    );

    // The held item moves on when the result register is free or draining.
    assign advance = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !advance;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_mask      <= '1;
            r_pos       <= '0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance && r_in_end) begin
                r_out_valid <= 1'b1;
                r_mask      <= '1;
                r_pos       <= '0;
            end else begin
                if (!i_stall) begin
                    r_out_valid <= 1'b0;
                end
                if (advance) begin
                    r_mask <= n_mask;
                    r_pos  <= n_pos;
                end
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_code <= i_char_code;
            r_in_end  <= i_is_end;
        end
        if (advance && r_in_end) begin
            r_result <= n_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_found         = r_result.found;
    assign o_keyword_index = r_result.keyword_index;

endmodule
`default_nettype wire

// ===== rtl/ckr_match.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// ckr_match
// Parallel keyword compare: next alive mask and position, and the lookup
// result for an end marker.
// ---------------------------------------------------------------------------
module ckr_match
    import ckr_pkg::*;
#(
    parameter int ACTIVE_COUNT    = DEF_KEYWORD_COUNT,
    parameter int MAX_WORD_LENGTH = DEF_MAX_WORD_LENGTH
) (
    input  wire logic [CHAR_W-1:0]       i_char_code,
    input  wire logic [ACTIVE_COUNT-1:0] i_mask,
    input  wire logic [POS_W-1:0]        i_pos,
    output logic      [ACTIVE_COUNT-1:0] o_mask_next,
    output logic      [POS_W-1:0]        o_pos_next,
    output t_result                      o_result
);

    logic                    in_range;
    logic [ACTIVE_COUNT-1:0] hit;
    logic [ACTIVE_COUNT-1:0] done;

    assign in_range = (i_pos < POS_W'(MAX_WORD_LENGTH))
                      && (i_char_code[CHAR_W-1:8] == '0);

    for (genvar k = 0; k < ACTIVE_COUNT; k++) begin : g_kw
        logic [7:0] c;
        assign c       = kw_char(k, i_pos);
        assign hit[k]  = in_range && (c != 8'h00) && (i_char_code[7:0] == c);
        assign done[k] = i_mask[k] && (i_pos != '0) && (KW_LEN[k] == i_pos);
    end

    assign o_mask_next = i_mask & hit;
    assign o_pos_next  = (i_pos == POS_MAX) ? i_pos : i_pos + 4'd1;

    // Keywords are distinct, so at most one entry can be done: OR the indices.
    always_comb begin
        o_result = '0;
        for (int k = 0; k < ACTIVE_COUNT; k++) begin
            if (done[k]) begin
                o_result.found         = 1'b1;
                o_result.keyword_index = o_result.keyword_index | INDEX_W'(k);
            end
        end
    end

endmodule
`default_nettype wire

// ===== test/c_keyword_recognizer_tb.sv =====
// ---------------------------------------------------------------------------
// c_keyword_recognizer_tb
// Self-checking bench for the C keyword recogniser. Words are streamed in a
// character an item and closed by an end marker; a scoreboard class keeps its
// own keyword table, alive mask and position count, and predicts the verdict
// of every word. Verdicts are compared field by field, in order, under random
// idling on both channels, one long receiver hold-off and a full drain mid-run.
// ---------------------------------------------------------------------------
module c_keyword_recognizer_tb;
    import ckr_pkg::*;

    localparam int KW_COUNT      = 44;
    localparam int LONGEST_WORD  = 14;
    localparam int TOTAL_ITEMS   = 1170;     // directed part plus ~1150 random
    localparam int HOLD_CYCLES   = 60;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int MAX_REPORTS   = 10;
    localparam logic [CHAR_W-1:0] TOP_CODE = 21'h10FFFF;

    // -----------------------------------------------------------------------
    // Verdict predictor and checker
    // -----------------------------------------------------------------------
    class keyword_scoreboard;
        string                kw_names[KW_COUNT];
        logic [KW_COUNT-1:0]  still_matching;
        logic [POS_W-1:0]     chars_seen;
        t_result              expected_verdicts[$];
        int                   mismatches;
        int                   words_checked;
        int                   keywords_hit;

        function new();
            kw_names = '{
                "auto", "break", "case", "char", "const", "continue", "default",
                "do", "double", "else", "enum", "extern", "float", "for", "goto",
                "if", "inline", "int", "long", "register", "restrict", "return",
                "short", "signed", "sizeof", "static", "struct", "switch",
                "typedef", "union", "unsigned", "void", "volatile", "while",
                "_Alignas", "_Alignof", "_Atomic", "_Bool", "_Complex",
                "_Generic", "_Imaginary", "_Noreturn", {"_Static", "_assert"},
                {"_Thread", "_local"}
            };
            mismatches    = 0;
            words_checked = 0;
            keywords_hit  = 0;
            start_word();
        endfunction

        function void start_word();
            still_matching = '1;
            chars_seen     = '0;
        endfunction

        // One accepted input item: a character narrows the mask, an end
        // marker turns the mask into a verdict and starts a fresh word.
        function void absorb_item(logic [CHAR_W-1:0] code, logic is_end);
            t_result verdict;
            int      k;
            if (!is_end) begin
                if (chars_seen >= LONGEST_WORD) begin
                    still_matching = '0;
                end else begin
                    for (k = 0; k < KW_COUNT; k++) begin
                        if (chars_seen >= kw_names[k].len() ||
                            code != CHAR_W'(kw_names[k][chars_seen])) begin
                            still_matching[k] = 1'b0;
                        end
                    end
                end
                if (chars_seen != POS_MAX) begin
                    chars_seen++;
                end
            end else begin
                verdict = '0;
                for (k = 0; k < KW_COUNT && !verdict.found; k++) begin
                    if (still_matching[k] && chars_seen != 0 &&
                        kw_names[k].len() == chars_seen) begin
                        verdict.found         = 1'b1;
                        verdict.keyword_index = INDEX_W'(k);
                    end
                end
                expected_verdicts.push_back(verdict);
                start_word();
            end
        endfunction

        function void check_verdict(logic found, logic [INDEX_W-1:0] index);
            t_result want;
            if (expected_verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected verdict: found=%0b index=%0d", found, index);
                end
                return;
            end
            want = expected_verdicts.pop_front();
            words_checked++;
            if (want.found) begin
                keywords_hit++;
            end
            if (found !== want.found || index !== want.keyword_index) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("word %0d: expected found=%0b index=%0d, got found=%0b index=%0d",
                             words_checked, want.found, want.keyword_index, found, index);
                end
            end
        endfunction

        function int outstanding();
            return expected_verdicts.size();
        endfunction
    endclass

    // -----------------------------------------------------------------------
    // DUT and its signals
    // -----------------------------------------------------------------------
    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [CHAR_W-1:0]  i_char_code;
    logic               i_is_end;
    logic               o_valid;
    logic               i_stall;
    logic               o_found;
    logic [INDEX_W-1:0] o_keyword_index;

    c_keyword_recognizer u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_code     (i_char_code),
        .i_is_end        (i_is_end),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_found         (o_found),
        .o_keyword_index (o_keyword_index)
    );

    keyword_scoreboard  sb;
    logic [CHAR_W-1:0]  word_codes[$];       // characters of the word being built
    int                 items_sent;
    int                 cycles;
    bit                 calm;                // no idling on either side
    bit                 hold_req;            // asks the receiver for a long hold-off
    string              alphabet = "abcdefghilmnorstuvwxyz_ABCGINST0";

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Run limit; a hung handshake ends here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts outstanding",
                     cycles, sb.outstanding());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Monitor: both channels sampled at the edge. The verdict leaving at this
    // edge belongs to an older word, so checking it first is safe.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                sb.check_verdict(o_found, o_keyword_index);
            end
            if (i_valid && !o_stall) begin
                sb.absorb_item(i_char_code, i_is_end);
            end
        end
    end

    // Receiver: random stall bursts, calm stretches and the one long hold-off.
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (!calm && $urandom_range(0, 39) == 0) begin
                repeat ($urandom_range(20, 60)) @(posedge i_clk);
            end
        end
    end

    // -----------------------------------------------------------------------
    // Sender tasks
    // -----------------------------------------------------------------------

    // Offer one item and wait for it to be taken. An optional gap first.
    task automatic offer(input logic [CHAR_W-1:0] code, input logic is_end);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= code;
        i_is_end    <= is_end;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic push_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) begin
            word_codes.push_back(CHAR_W'(s[i]));
        end
    endtask

    // Stream word_codes, then the end marker with an arbitrary (ignored) code.
    task automatic send_word(input logic [CHAR_W-1:0] end_code);
        int i;
        for (i = 0; i < word_codes.size(); i++) begin
            offer(word_codes[i], 1'b0);
        end
        offer(end_code, 1'b1);
        word_codes.delete();
    endtask

    // Input side goes quiet until every verdict is back; always advances time
    // so the next offer never lands in the same step as the lowering of valid.
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    function automatic logic [CHAR_W-1:0] any_letter();
        return CHAR_W'(alphabet[$urandom_range(0, alphabet.len() - 1)]);
    endfunction

    // Real keywords, the largest share, with near misses, prefixes, overlong tails,
    // wide codes aliasing a keyword byte, and some plain noise.
    task automatic build_random_word();
        int    kind;
        int    k;
        int    n;
        int    p;
        string w;
        kind = $urandom_range(0, 99);
        k    = $urandom_range(0, KW_COUNT - 1);
        w    = sb.kw_names[k];
        if (kind < 40) begin
            push_text(w);
        end else if (kind < 52) begin
            push_text(w);
            p = $urandom_range(0, w.len() - 1);
            word_codes[p] = any_letter();
        end else if (kind < 60) begin
            // low byte still right, one upper bit set
            push_text(w);
            p = $urandom_range(0, w.len() - 1);
            word_codes[p] = word_codes[p] | (CHAR_W'(1) << $urandom_range(8, 20));
        end else if (kind < 68) begin
            push_text(w.substr(0, $urandom_range(0, w.len() - 2)));
        end else if (kind < 78) begin
            // keyword plus tail; the two longest ones can run past the limit
            if ($urandom_range(0, 1) == 0) begin
                w = sb.kw_names[$urandom_range(KW_COUNT - 2, KW_COUNT - 1)];
            end
            push_text(w);
            n = $urandom_range(1, 4);
            repeat (n) word_codes.push_back(any_letter());
        end else if (kind < 90) begin
            n = $urandom_range(0, 17);
            repeat (n) word_codes.push_back(any_letter());
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) word_codes.push_back(CHAR_W'($urandom_range(0, TOP_CODE)));
        end
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial begin
        bit held;
        bit drained;
        sb          = new();
        items_sent  = 0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        held        = 1'b0;
        drained     = 1'b0;
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_char_code <= '0;
        i_is_end    <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words
        send_word(TOP_CODE);                      // empty word
        push_text("do");
        send_word('0);                            // shortest keyword
        push_text("if");
        send_word(21'h0FFFFF);                    // end code is ignored
        push_text("auto");
        send_word(21'h155555);
        word_codes.push_back(CHAR_W'("d"));       // zero code mid-word
        word_codes.push_back('0);
        word_codes.push_back(CHAR_W'("o"));
        send_word(21'h0AAAAA);
        word_codes.push_back(TOP_CODE);           // non-ASCII only
        send_word('0);
        push_text("zdo");                         // chars after a mismatch
        send_word('0);

        // Random words
        while (items_sent < TOTAL_ITEMS) begin
            if (!held && items_sent > 350) begin
                hold_req = 1'b1;                  // sender keeps offering meanwhile
                held     = 1'b1;
            end
            if (!drained && items_sent > 700) begin
                drain();
                drained = 1'b1;
            end
            if (items_sent > 1000) begin
                calm = 1'b1;
            end
            build_random_word();
            send_word(CHAR_W'($urandom_range(0, TOP_CODE)));
        end

        drain();
        repeat (8) @(posedge i_clk);             // any stray verdict shows up here

        $display("%0d items streamed, %0d words checked, %0d keywords recognised",
                 items_sent, sb.words_checked, sb.keywords_hit);
        $display("%0d mismatches, %0d verdicts left over",
                 sb.mismatches, sb.outstanding());
        if (sb.mismatches == 0 && sb.outstanding() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
